// ===== rtl/core/ora_pkg.sv =====
// ============================================================================
// ora_pkg - shared types and constants of the out-of-range alarm monitor
// Word formats, state and event codes, register indexes and sequencer states.
// ============================================================================
`default_nettype none

package ora_pkg;

    localparam int MAX_NOTES_DEF    = 8;
    localparam int TIMER_PASSES_DEF = 8;

    localparam logic [31:0] MAX_STEP = 32'h7FFF_FFFF;

    // Opcodes of an input word.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_ACK    = 2'd2;
    localparam logic [1:0] OP_MAINT  = 2'd3;

    // Point states.
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_HIGH   = 2'd1;
    localparam logic [1:0] ST_LOW    = 2'd2;
    localparam logic [1:0] ST_FAULT  = 2'd3;

    // Note events; the first four follow the point state codes.
    localparam logic [2:0] EV_OVERDUE = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_HIGH_LIMIT  = 3'd0;
    localparam logic [2:0] REG_HIGH_ENABLE = 3'd1;
    localparam logic [2:0] REG_LOW_LIMIT   = 3'd2;
    localparam logic [2:0] REG_LOW_ENABLE  = 3'd3;
    localparam logic [2:0] REG_DEADBAND    = 3'd4;
    localparam logic [2:0] REG_DELAY       = 3'd5;
    localparam logic [2:0] REG_ESCALATE    = 3'd6;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        now_seconds;
        logic signed [31:0] sample_value;
        logic               bad_reading;
        logic               maint_on;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         point_state;
        logic               has_note;
        logic [2:0]         note_event;
        logic [31:0]        note_time;
        logic signed [31:0] note_value;
        logic               last;
    } t_out_word;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CLOCK,
        SEQ_TR_DUE,
        SEQ_ES_DUE,
        SEQ_DECIDE,
        SEQ_APPLY,
        SEQ_EMIT
    } t_seq_state;

endpackage

`default_nettype wire

// ===== rtl/core/out_of_range_alarm_core.sv =====
// ============================================================================
// out_of_range_alarm_core - alarm monitor for one analog point
// Limit, deadband and delay supervision with fault, acknowledgement,
// escalation and maintenance suppression, driven by time-stamped input words.
// ============================================================================
`default_nettype none

// One input word is taken at a time. After acceptance the sequencer advances
// the 64-bit monotonic clock, then runs up to TIMER_PASSES timer passes for
// events due strictly before the word's time, applies the word, and runs up
// to TIMER_PASSES more passes for events due at that time; a tick word skips
// the first passes and the apply step. Each timer pass has three steps:
// transition due time and escalation due time on the shared 64-bit adder,
// then the decision. Results are then delivered one word per accepted output
// handshake: one word per note, or a single word without a note, with last
// marking the final one; notes beyond MAX_NOTES within one input word are
// dropped. The input is not ready again until the last result word has been
// taken. Configuration is to be written over the APB-style port only while
// the block is idle; the block itself does not enforce this.
module out_of_range_alarm_core
    import ora_pkg::*;
#(
    parameter int MAX_NOTES    = MAX_NOTES_DEF,
    parameter int TIMER_PASSES = TIMER_PASSES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in_word    i_in_word,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    output      t_out_word   o_out_word,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int CNT_W  = $clog2(MAX_NOTES + 1);
    localparam int IDX_W  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int PASS_W = (TIMER_PASSES > 1) ? $clog2(TIMER_PASSES) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_high_limit, r_low_limit, r_delay, r_escalate;
    logic [30:0] r_deadband;
    logic        r_high_enable, r_low_enable;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_limit  <= '0;
            r_high_enable <= 1'b0;
            r_low_limit   <= '0;
            r_low_enable  <= 1'b0;
            r_deadband    <= '0;
            r_delay       <= '0;
            r_escalate    <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_HIGH_LIMIT:  r_high_limit  <= pwdata;
                REG_HIGH_ENABLE: r_high_enable <= pwdata[0];
                REG_LOW_LIMIT:   r_low_limit   <= pwdata;
                REG_LOW_ENABLE:  r_low_enable  <= pwdata[0];
                REG_DEADBAND:    r_deadband    <= pwdata[30:0];
                REG_DELAY:       r_delay       <= pwdata;
                REG_ESCALATE:    r_escalate    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_HIGH_LIMIT:  prdata = r_high_limit;
            REG_HIGH_ENABLE: prdata = {31'd0, r_high_enable};
            REG_LOW_LIMIT:   prdata = r_low_limit;
            REG_LOW_ENABLE:  prdata = {31'd0, r_low_enable};
            REG_DEADBAND:    prdata = {1'b0, r_deadband};
            REG_DELAY:       prdata = r_delay;
            REG_ESCALATE:    prdata = r_escalate;
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Point state and sequencer registers
    // ------------------------------------------------------------------
    t_seq_state  r_seq, n_seq;
    t_in_word    r_in, n_in;
    logic [31:0] r_last_stamp, n_last_stamp;
    logic [63:0] r_mono, n_mono;
    logic [63:0] r_pending_since, n_pending_since;
    logic [63:0] r_announce_time, n_announce_time;
    logic [31:0] r_held, n_held;
    logic [1:0]  r_alarm, n_alarm;
    logic [1:0]  r_pending, n_pending;
    logic [1:0]  r_notified, n_notified;
    logic        r_maint, n_maint;
    logic        r_announced, n_announced;
    logic        r_acked, n_acked;
    logic        r_escalated, n_escalated;
    logic        r_entered, n_entered;
    logic        r_inclusive, n_inclusive;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic [CNT_W-1:0]  r_note_cnt, n_note_cnt;
    logic [CNT_W-1:0]  r_emit_idx, n_emit_idx;
    logic [63:0] r_tr_due, n_tr_due;
    logic [63:0] r_es_due, n_es_due;

    // Note buffer: written at the fill count, read at the emit index.
    logic [2:0]  r_note_ev  [MAX_NOTES];
    logic [31:0] r_note_val [MAX_NOTES];
    logic        note_wr;
    logic [2:0]  note_ev_wr;

    // Shared 64-bit adder: one due time per cycle.
    logic [63:0] add_a, add_sum;
    logic [31:0] add_b;
    assign add_sum = add_a + {32'd0, add_b};

    // Limit comparisons of the indicated state, at 34 bits so that the limit
    // with deadband never wraps.
    logic signed [33:0] v34, hi34, lo34, db34;
    logic [1:0] base_st, ind_st;

    always_comb begin
        v34  = {{2{n_held[31]}}, n_held};
        hi34 = {{2{r_high_limit[31]}}, r_high_limit};
        lo34 = {{2{r_low_limit[31]}}, r_low_limit};
        db34 = {3'd0, r_deadband};
        base_st = (r_alarm == ST_FAULT) ? ST_NORMAL : r_alarm;
        case (base_st)
            ST_HIGH: begin
                if (!(r_high_enable && v34 < hi34 - db34)) begin
                    ind_st = ST_HIGH;
                end else begin
                    ind_st = (r_low_enable && v34 < lo34) ? ST_LOW : ST_NORMAL;
                end
            end
            ST_LOW: begin
                if (!(r_low_enable && v34 > lo34 + db34)) begin
                    ind_st = ST_LOW;
                end else begin
                    ind_st = (r_high_enable && v34 > hi34) ? ST_HIGH : ST_NORMAL;
                end
            end
            default: begin
                if (r_high_enable && v34 > hi34) begin
                    ind_st = ST_HIGH;
                end else if (r_low_enable && v34 < lo34) begin
                    ind_st = ST_LOW;
                end else begin
                    ind_st = ST_NORMAL;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and point updates
    // ------------------------------------------------------------------
    logic        want_enter, want_announce, want_escalate;
    logic [1:0]  enter_st;
    logic        set_pending;
    logic        tr_hit, es_hit;
    logic [31:0] step;

    always_comb begin
        n_seq           = r_seq;
        n_in            = r_in;
        n_last_stamp    = r_last_stamp;
        n_mono          = r_mono;
        n_pending_since = r_pending_since;
        n_announce_time = r_announce_time;
        n_held          = r_held;
        n_alarm         = r_alarm;
        n_pending       = r_pending;
        n_notified      = r_notified;
        n_maint         = r_maint;
        n_announced     = r_announced;
        n_acked         = r_acked;
        n_escalated     = r_escalated;
        n_entered       = r_entered;
        n_inclusive     = r_inclusive;
        n_pass          = r_pass;
        n_note_cnt      = r_note_cnt;
        n_emit_idx      = r_emit_idx;
        n_tr_due        = r_tr_due;
        n_es_due        = r_es_due;
        want_enter      = 1'b0;
        want_announce   = 1'b0;
        want_escalate   = 1'b0;
        enter_st        = ST_NORMAL;
        set_pending     = 1'b0;
        note_wr         = 1'b0;
        note_ev_wr      = EV_OVERDUE;
        add_a           = r_pending_since;
        add_b           = r_delay;
        step            = r_in.now_seconds - r_last_stamp;
        tr_hit          = 1'b0;
        es_hit          = 1'b0;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;

        unique case (r_seq)
            SEQ_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_in  = i_in_word;
                    n_seq = SEQ_CLOCK;
                end
            end
            SEQ_CLOCK: begin
                add_a = r_mono;
                add_b = step;
                if (step <= MAX_STEP) begin
                    n_mono       = add_sum;
                    n_last_stamp = r_in.now_seconds;
                end
                n_note_cnt  = '0;
                n_emit_idx  = '0;
                n_entered   = 1'b0;
                n_pass      = '0;
                n_inclusive = (r_in.opcode == OP_TICK);
                n_seq       = SEQ_TR_DUE;
            end
            SEQ_TR_DUE: begin
                n_tr_due = add_sum;
                n_seq    = SEQ_ES_DUE;
            end
            SEQ_ES_DUE: begin
                add_a    = r_announce_time;
                add_b    = r_escalate;
                n_es_due = add_sum;
                n_seq    = SEQ_DECIDE;
            end
            SEQ_DECIDE: begin
                if (r_alarm != ST_FAULT && r_pending != r_alarm) begin
                    tr_hit = r_inclusive ? (r_tr_due <= r_mono) : (r_tr_due < r_mono);
                end
                if (r_alarm != ST_NORMAL && r_announced && !r_acked && !r_escalated &&
                    !r_maint) begin
                    es_hit = r_inclusive ? (r_es_due <= r_mono) : (r_es_due < r_mono);
                end
                if (es_hit && (!tr_hit || r_es_due < r_tr_due)) begin
                    n_escalated   = 1'b1;
                    want_escalate = 1'b1;
                end else if (tr_hit) begin
                    want_enter = 1'b1;
                    enter_st   = r_pending;
                end
                if (!(tr_hit || es_hit) || r_pass == PASS_W'(TIMER_PASSES - 1)) begin
                    n_pass = '0;
                    n_seq  = r_inclusive ? SEQ_EMIT : SEQ_APPLY;
                end else begin
                    n_pass = r_pass + 1'b1;
                    n_seq  = SEQ_TR_DUE;
                end
            end
            SEQ_APPLY: begin
                n_inclusive = 1'b1;
                n_seq       = SEQ_TR_DUE;
                case (r_in.opcode)
                    OP_SAMPLE: begin
                        n_held = r_in.sample_value;
                        if (r_in.bad_reading) begin
                            if (r_alarm != ST_FAULT) begin
                                want_enter = 1'b1;
                                enter_st   = ST_FAULT;
                            end
                        end else begin
                            if (r_alarm == ST_FAULT) begin
                                want_enter = 1'b1;
                                enter_st   = ST_NORMAL;
                            end
                            set_pending = 1'b1;
                        end
                    end
                    OP_ACK: begin
                        if (!r_entered && r_alarm != ST_NORMAL && r_announced) begin
                            n_acked = 1'b1;
                        end
                    end
                    OP_MAINT: begin
                        if (r_in.maint_on) begin
                            n_maint = 1'b1;
                        end else if (r_maint) begin
                            n_maint = 1'b0;
                            if (!r_announced) begin
                                if (r_alarm != ST_NORMAL || r_notified != ST_NORMAL) begin
                                    want_announce = 1'b1;
                                end else begin
                                    n_announced = 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            SEQ_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (o_out_word.last) begin
                        n_seq = SEQ_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + 1'b1;
                    end
                end
            end
            default: n_seq = SEQ_IDLE;
        endcase

        // Entering a state, announced at once unless in maintenance.
        if (want_enter) begin
            n_alarm     = enter_st;
            n_pending   = enter_st;
            n_entered   = 1'b1;
            n_announced = 1'b0;
            n_acked     = 1'b0;
            n_escalated = 1'b0;
            if (!r_maint) begin
                want_announce = 1'b1;
            end
        end
        if (want_announce) begin
            note_wr         = 1'b1;
            note_ev_wr      = {1'b0, n_alarm};
            n_notified      = n_alarm;
            n_announced     = 1'b1;
            n_acked         = 1'b0;
            n_escalated     = 1'b0;
            n_announce_time = r_mono;
        end
        if (want_escalate) begin
            note_wr    = 1'b1;
            note_ev_wr = EV_OVERDUE;
        end
        if (set_pending && ind_st != n_pending) begin
            n_pending       = ind_st;
            n_pending_since = r_mono;
        end
        if (note_wr && r_note_cnt < CNT_W'(MAX_NOTES)) begin
            n_note_cnt = r_note_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq           <= SEQ_IDLE;
            r_last_stamp    <= '0;
            r_mono          <= '0;
            r_pending_since <= '0;
            r_announce_time <= '0;
            r_held          <= '0;
            r_alarm         <= ST_NORMAL;
            r_pending       <= ST_NORMAL;
            r_notified      <= ST_NORMAL;
            r_maint         <= 1'b0;
            r_announced     <= 1'b1;
            r_acked         <= 1'b0;
            r_escalated     <= 1'b0;
            r_entered       <= 1'b0;
            r_inclusive     <= 1'b0;
            r_pass          <= '0;
            r_note_cnt      <= '0;
            r_emit_idx      <= '0;
        end else begin
            r_seq           <= n_seq;
            r_last_stamp    <= n_last_stamp;
            r_mono          <= n_mono;
            r_pending_since <= n_pending_since;
            r_announce_time <= n_announce_time;
            r_held          <= n_held;
            r_alarm         <= n_alarm;
            r_pending       <= n_pending;
            r_notified      <= n_notified;
            r_maint         <= n_maint;
            r_announced     <= n_announced;
            r_acked         <= n_acked;
            r_escalated     <= n_escalated;
            r_entered       <= n_entered;
            r_inclusive     <= n_inclusive;
            r_pass          <= n_pass;
            r_note_cnt      <= n_note_cnt;
            r_emit_idx      <= n_emit_idx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_tr_due <= n_tr_due;
        r_es_due <= n_es_due;
        if (note_wr && r_note_cnt < CNT_W'(MAX_NOTES)) begin
            r_note_ev[r_note_cnt[IDX_W-1:0]]  <= note_ev_wr;
            r_note_val[r_note_cnt[IDX_W-1:0]] <= n_held;
        end
    end

    // ------------------------------------------------------------------
    // Result word: one per note, or a single word without a note.
    // ------------------------------------------------------------------
    always_comb begin
        o_out_word.point_state = r_alarm;
        if (r_note_cnt == '0) begin
            o_out_word.has_note   = 1'b0;
            o_out_word.note_event = '0;
            o_out_word.note_time  = '0;
            o_out_word.note_value = '0;
            o_out_word.last       = 1'b1;
        end else begin
            o_out_word.has_note   = 1'b1;
            o_out_word.note_event = r_note_ev[r_emit_idx[IDX_W-1:0]];
            o_out_word.note_time  = r_in.now_seconds;
            o_out_word.note_value = r_note_val[r_emit_idx[IDX_W-1:0]];
            o_out_word.last       = (r_emit_idx + 1'b1 == r_note_cnt);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_note_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_note_cnt <= CNT_W'(MAX_NOTES))
        else $error("note count beyond buffer depth");

    a_fault_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm == ST_FAULT |-> r_pending == ST_FAULT)
        else $error("pending state differs while in fault");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !o_out_valid)
        else $error("input ready again straight after acceptance");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_word.last |=> o_in_ready && !o_out_valid)
        else $error("block not idle after final result word");

endmodule

`default_nettype wire
